@@ rtl/vpa_pkg.sv @@
package vpa_pkg;

    localparam int FREE_SLOTS = 16;
    localparam int HELD_SLOTS = 16;
    localparam int ADDR_BITS  = 16;
    localparam int OWNER_BITS = 8;
    localparam int LEN_BITS   = ADDR_BITS + 1;
    localparam int FIDX_BITS  = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int HIDX_BITS  = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
    localparam int CFG_BITS   = 17;
    localparam int CIDX_BITS  = 2;

    localparam logic [CIDX_BITS-1:0] REG_MEMORY_SIZE     = 2'd0;
    localparam logic [CIDX_BITS-1:0] REG_FIT_POLICY      = 2'd1;
    localparam logic [CIDX_BITS-1:0] REG_SPLIT_THRESHOLD = 2'd2;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_HELD_FULL = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FREE_FULL = 3'd4;
    localparam logic [2:0] ST_BAD       = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ASCAN,     // scan free cells for best pick
        S_HSCAN,     // scan held slots for empty
        S_AUPD,      // commit allocation
        S_RFIND,     // find next held block of owner
        S_RSCAN,     // scan free cells for neighbors / empty
        S_RUPD,      // commit give-back
        S_DONE
    } state_t;

    // broadcast command into every free cell
    typedef enum logic [2:0] {
        C_NONE,
        C_CLEAR,     // target: valid, start = 0, len = l; others invalid
        C_SHRINK,    // target: start += l, len -= l
        C_KILL,      // target invalid
        C_ADDLEN,    // target: len += l
        C_SETBOTH,   // target: start = s, len += l
        C_FILL       // target: valid, start = s, len = l
    } fcmd_kind_t;

    typedef struct packed {
        fcmd_kind_t               kind;
        logic [FIDX_BITS-1:0]     target;
        logic [ADDR_BITS-1:0]     s;
        logic [LEN_BITS-1:0]      l;
    } fcmd_t;

    typedef struct packed {
        logic                     ok;
        logic [ADDR_BITS-1:0]     start;
        logic [LEN_BITS-1:0]      len;
    } fent_t;

endpackage

@@ rtl/vpa_free_cell.sv @@
module vpa_free_cell
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [vpa_pkg::FIDX_BITS-1:0]    my_idx,
    input  logic                             rot,
    input  vpa_pkg::fent_t                   shift_in,
    input  vpa_pkg::fcmd_t                   cmd,
    output vpa_pkg::fent_t                   ent
);
    import vpa_pkg::*;

    fent_t ent_reg;
    fent_t ent_next;
    logic  hit;

    assign hit = (cmd.target == my_idx);
    assign ent = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        if (rot)
        begin
            ent_next = shift_in;
        end
        else
        begin
            unique case (cmd.kind)
                C_CLEAR:
                begin
                    ent_next.ok    = hit;
                    ent_next.start = '0;
                    ent_next.len   = hit ? cmd.l : '0;
                end
                C_SHRINK:
                    if (hit)
                    begin
                        ent_next.start = ent_reg.start + cmd.l[ADDR_BITS-1:0];
                        ent_next.len   = ent_reg.len - cmd.l;
                    end
                C_KILL:
                    if (hit)
                    begin
                        ent_next = '0;
                    end
                C_ADDLEN:
                    if (hit)
                    begin
                        ent_next.len = ent_reg.len + cmd.l;
                    end
                C_SETBOTH:
                    if (hit)
                    begin
                        ent_next.start = cmd.s;
                        ent_next.len   = ent_reg.len + cmd.l;
                    end
                C_FILL:
                    if (hit)
                    begin
                        ent_next.ok    = 1'b1;
                        ent_next.start = cmd.s;
                        ent_next.len   = cmd.l;
                    end
                default:
                    ent_next = ent_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg.ok    <= (my_idx == '0);
            ent_reg.start <= '0;
            ent_reg.len   <= (my_idx == '0) ? LEN_BITS'(1) << ADDR_BITS : '0;
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end

endmodule

@@ rtl/vpa_free_chain.sv @@
module vpa_free_chain
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rot,
    input  vpa_pkg::fcmd_t        cmd,
    output vpa_pkg::fent_t        head
);
    import vpa_pkg::*;

    fent_t ents [FREE_SLOTS];

    // rotation: cell i takes cell i+1, last takes head; after FREE_SLOTS
    // steps the ring is back in place
    for (genvar i = 0; i < FREE_SLOTS; i++)
    begin : g_cell
        vpa_free_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_idx   (FIDX_BITS'(i)),
            .rot      (rot),
            .shift_in (ents[(i + 1) % FREE_SLOTS]),
            .cmd      (cmd),
            .ent      (ents[i])
        );
    end

    assign head = ents[0];

endmodule

@@ rtl/variable_partition_allocator.sv @@
// channel | valid    | stall    | word
// in      | in_valid | in_stall | kind, request_size, owner_id
// out     | out_valid| out_stall| status, grant_begin, grant_length
// One word at a time. Allocate: a free ring scan, a held slot scan, then the
// commit. Release: per owned block one held step, a free ring scan and an
// update, plus the held scan. Clear: both tables reset on accept. The free table is a ring of
// cells rotated once around per scan. Reset loads one free block of 2^16.
// in_stall stays high from accept until the result is taken.
module variable_partition_allocator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [vpa_pkg::CIDX_BITS-1:0]   cfg_index,
    input  logic [vpa_pkg::CFG_BITS-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      kind,
    input  logic [16:0]                     request_size,
    input  logic [7:0]                      owner_id,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status,
    output logic [15:0]                     grant_begin,
    output logic [16:0]                     grant_length
);
    import vpa_pkg::*;

    logic [LEN_BITS-1:0]  mem_size_reg;
    logic [1:0]           fit_reg;
    logic [15:0]          thr_reg;

    state_t               state_reg, state_next;
    logic [LEN_BITS-1:0]  req_reg;
    logic [OWNER_BITS-1:0] own_reg;

    logic [FIDX_BITS:0]   cnt_reg, cnt_next;
    logic [FIDX_BITS-1:0] pos;

    logic                 pick_ok_reg, pick_ok_next;
    logic [FIDX_BITS-1:0] pick_reg, pick_next;
    logic [ADDR_BITS-1:0] pick_s_reg, pick_s_next;
    logic [LEN_BITS-1:0]  pick_l_reg, pick_l_next;

    logic                 lft_ok_reg, lft_ok_next, rgt_ok_reg, rgt_ok_next;
    logic                 emp_ok_reg, emp_ok_next;
    logic [FIDX_BITS-1:0] lft_reg, lft_next, rgt_reg, rgt_next, emp_reg, emp_next;
    logic [LEN_BITS-1:0]  rgt_l_reg, rgt_l_next;

    logic                 held_ok_reg [HELD_SLOTS];
    logic [ADDR_BITS-1:0] held_start_reg [HELD_SLOTS];
    logic [LEN_BITS-1:0]  held_len_reg [HELD_SLOTS];
    logic [OWNER_BITS-1:0] held_owner_reg [HELD_SLOTS];

    logic [HIDX_BITS:0]   hcnt_reg, hcnt_next;
    logic [HIDX_BITS-1:0] hpos;
    logic                 slot_ok_reg, slot_ok_next;
    logic [HIDX_BITS-1:0] slot_reg, slot_next;
    logic                 found_reg, found_next, any_reg, any_next;
    logic [ADDR_BITS-1:0] low_reg, low_next;
    logic [LEN_BITS-1:0]  tot_reg, tot_next;
    logic [ADDR_BITS-1:0] cur_s;
    logic [LEN_BITS-1:0]  cur_l;

    logic [2:0]           st_reg, st_next;
    logic [ADDR_BITS-1:0] gb_reg, gb_next;
    logic [LEN_BITS-1:0]  gl_reg, gl_next;

    logic                 rot;
    fcmd_t                cmd;
    fent_t                head;
    logic                 better;
    logic [LEN_BITS:0]    head_end, cur_end;
    logic [LEN_BITS-1:0]  msz;
    logic                 held_clr, held_set, held_free;
    logic [LEN_BITS-1:0]  leftover;

    // second half of a two-sided merge runs in the following cycle
    logic                 merge_reg;
    logic [FIDX_BITS-1:0] merge_idx_reg;
    logic [LEN_BITS-1:0]  merge_len_reg;
    fcmd_t                cmd_mux;

    vpa_free_chain u_chain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rot   (rot),
        .cmd   (cmd_mux),
        .head  (head)
    );

    assign pos  = cnt_reg[FIDX_BITS-1:0];
    assign hpos = hcnt_reg[HIDX_BITS-1:0];
    assign cur_s = held_start_reg[slot_reg];
    assign cur_l = held_len_reg[slot_reg];
    assign head_end = {1'b0, head.len} + (LEN_BITS + 1)'(head.start);
    assign cur_end  = {1'b0, cur_l} + (LEN_BITS + 1)'(cur_s);
    assign leftover = pick_l_reg - req_reg;

    always_comb
    begin
        msz = mem_size_reg;
        if (msz == '0)
        begin
            msz = LEN_BITS'(1);
        end
        else if (msz > (LEN_BITS'(1) << ADDR_BITS))
        begin
            msz = LEN_BITS'(1) << ADDR_BITS;
        end
    end

    always_comb
    begin
        priority if (!pick_ok_reg)
            better = 1'b1;
        else if (fit_reg == FIT_BEST && head.len != pick_l_reg)
            better = head.len < pick_l_reg;
        else if (fit_reg == FIT_WORST && head.len != pick_l_reg)
            better = head.len > pick_l_reg;
        else
            better = head.start < pick_s_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_size_reg <= LEN_BITS'(1) << ADDR_BITS;
            fit_reg      <= '0;
            thr_reg      <= 16'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MEMORY_SIZE:     mem_size_reg <= cfg_data;
                REG_FIT_POLICY:      fit_reg      <= cfg_data[1:0];
                REG_SPLIT_THRESHOLD: thr_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    unique case (kind)
                        KIND_ALLOC:
                            state_next = (request_size == '0) ? S_DONE : S_ASCAN;
                        KIND_RELEASE: state_next = S_RFIND;
                        default:      state_next = S_DONE;
                    endcase
                end
            S_ASCAN:
                if (cnt_reg == (FIDX_BITS + 1)'(FREE_SLOTS - 1))
                begin
                    state_next = (pick_ok_next) ? S_HSCAN : S_DONE;
                end
            S_HSCAN:
                if (hcnt_reg == (HIDX_BITS + 1)'(HELD_SLOTS - 1))
                begin
                    state_next = slot_ok_next ? S_AUPD : S_DONE;
                end
            S_AUPD:  state_next = S_DONE;
            S_RFIND:
                if (slot_ok_next)
                begin
                    state_next = S_RSCAN;
                end
                else if (hcnt_reg == (HIDX_BITS + 1)'(HELD_SLOTS - 1))
                begin
                    state_next = S_DONE;
                end
            S_RSCAN:
                if (cnt_reg == (FIDX_BITS + 1)'(FREE_SLOTS - 1))
                begin
                    state_next = S_RUPD;
                end
            S_RUPD:
                if (!lft_ok_reg && !rgt_ok_reg && !emp_ok_reg)
                    state_next = S_DONE;
                else if (hcnt_reg == (HIDX_BITS + 1)'(HELD_SLOTS))
                    state_next = S_DONE;
                else
                    state_next = S_RFIND;
            S_DONE:
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath / outputs
    always_comb
    begin
        cnt_next     = cnt_reg;
        hcnt_next    = hcnt_reg;
        pick_ok_next = pick_ok_reg;
        pick_next    = pick_reg;
        pick_s_next  = pick_s_reg;
        pick_l_next  = pick_l_reg;
        lft_ok_next  = lft_ok_reg;
        rgt_ok_next  = rgt_ok_reg;
        emp_ok_next  = emp_ok_reg;
        lft_next     = lft_reg;
        rgt_next     = rgt_reg;
        emp_next     = emp_reg;
        rgt_l_next   = rgt_l_reg;
        slot_ok_next = slot_ok_reg;
        slot_next    = slot_reg;
        found_next   = found_reg;
        any_next     = any_reg;
        low_next     = low_reg;
        tot_next     = tot_reg;
        st_next      = st_reg;
        gb_next      = gb_reg;
        gl_next      = gl_reg;
        rot          = 1'b0;
        cmd          = '0;
        cmd.kind     = C_NONE;
        held_clr     = 1'b0;
        held_set     = 1'b0;
        held_free    = 1'b0;

        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cnt_next     = '0;
                    hcnt_next    = '0;
                    pick_ok_next = 1'b0;
                    slot_ok_next = 1'b0;
                    found_next   = 1'b0;
                    any_next     = 1'b0;
                    low_next     = '0;
                    tot_next     = '0;
                    st_next      = ST_OK;
                    gb_next      = '0;
                    gl_next      = '0;
                    unique case (kind)
                        KIND_ALLOC:
                            if (request_size == '0)
                                st_next = ST_BAD;
                        KIND_RELEASE: ;
                        KIND_CLEAR:
                        begin
                            cmd.kind = C_CLEAR;
                            cmd.l    = msz;
                            held_clr = 1'b1;
                            gl_next  = msz;
                        end
                        default: st_next = ST_BAD;
                    endcase
                end
            S_ASCAN:
            begin
                rot = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (head.ok && head.len >= req_reg && better)
                begin
                    pick_ok_next = 1'b1;
                    pick_next    = pos;
                    pick_s_next  = head.start;
                    pick_l_next  = head.len;
                end
                if (cnt_reg == (FIDX_BITS + 1)'(FREE_SLOTS - 1) && !pick_ok_next)
                    st_next = ST_NO_FIT;
            end
            S_HSCAN:
            begin
                hcnt_next = hcnt_reg + 1'b1;
                if (!slot_ok_reg && !held_ok_reg[hpos])
                begin
                    slot_ok_next = 1'b1;
                    slot_next    = hpos;
                end
                if (hcnt_reg == (HIDX_BITS + 1)'(HELD_SLOTS - 1) && !slot_ok_next)
                    st_next = ST_HELD_FULL;
            end
            S_AUPD:
            begin
                held_set   = 1'b1;
                cmd.target = pick_reg;
                gb_next    = pick_s_reg;
                if (leftover <= {1'b0, thr_reg})
                begin
                    cmd.kind = C_KILL;
                    gl_next  = pick_l_reg;
                end
                else
                begin
                    cmd.kind = C_SHRINK;
                    cmd.l    = req_reg;
                    gl_next  = req_reg;
                end
            end
            S_RFIND:
            begin
                hcnt_next = hcnt_reg + 1'b1;
                if (held_ok_reg[hpos] && held_owner_reg[hpos] == own_reg)
                begin
                    slot_ok_next = 1'b1;
                    slot_next    = hpos;
                    found_next   = 1'b1;
                    cnt_next     = '0;
                    lft_ok_next  = 1'b0;
                    rgt_ok_next  = 1'b0;
                    emp_ok_next  = 1'b0;
                end
                else
                begin
                    slot_ok_next = 1'b0;
                    if (hcnt_reg == (HIDX_BITS + 1)'(HELD_SLOTS - 1) && !found_reg)
                        st_next = ST_NOT_FOUND;
                end
            end
            S_RSCAN:
            begin
                rot = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (head.ok)
                begin
                    if (head_end == (LEN_BITS + 1)'(cur_s))
                    begin
                        lft_ok_next = 1'b1;
                        lft_next    = pos;
                    end
                    if ((LEN_BITS + 1)'(head.start) == cur_end)
                    begin
                        rgt_ok_next = 1'b1;
                        rgt_next    = pos;
                        rgt_l_next  = head.len;
                    end
                end
                else if (!emp_ok_reg)
                begin
                    emp_ok_next = 1'b1;
                    emp_next    = pos;
                end
            end
            S_RUPD:
            begin
                slot_ok_next = 1'b0;
                if (lft_ok_reg && rgt_ok_reg)
                begin
                    // two-step merge: kill right now, grow left below
                    cmd.kind   = C_KILL;
                    cmd.target = rgt_reg;
                end
                else if (lft_ok_reg)
                begin
                    cmd.kind   = C_ADDLEN;
                    cmd.target = lft_reg;
                    cmd.l      = cur_l;
                end
                else if (rgt_ok_reg)
                begin
                    cmd.kind   = C_SETBOTH;
                    cmd.target = rgt_reg;
                    cmd.s      = cur_s;
                    cmd.l      = cur_l;
                end
                else if (emp_ok_reg)
                begin
                    cmd.kind   = C_FILL;
                    cmd.target = emp_reg;
                    cmd.s      = cur_s;
                    cmd.l      = cur_l;
                end
                if (lft_ok_reg || rgt_ok_reg || emp_ok_reg)
                begin
                    held_free = 1'b1;
                    if (!any_reg || cur_s < low_reg)
                        low_next = cur_s;
                    any_next = 1'b1;
                    tot_next = tot_reg + cur_l;
                    gb_next  = (!any_reg || cur_s < low_reg) ? cur_s : low_reg;
                    gl_next  = tot_reg + cur_l;
                    // left+right: pending grow of left by l + right len
                    rgt_ok_next = 1'b0;
                    if (lft_ok_reg && rgt_ok_reg)
                    begin
                        rgt_l_next = cur_l + rgt_l_reg;
                    end
                end
                else
                begin
                    st_next = ST_FREE_FULL;
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_comb
    begin
        cmd_mux = cmd;
        if (merge_reg)
        begin
            cmd_mux.kind   = C_ADDLEN;
            cmd_mux.target = merge_idx_reg;
            cmd_mux.l      = merge_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_reg <= 1'b0;
        end
        else
        begin
            merge_reg <= (state_reg == S_RUPD) && lft_ok_reg && rgt_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        merge_idx_reg <= lft_reg;
        merge_len_reg <= cur_l + rgt_l_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            hcnt_reg    <= '0;
            pick_ok_reg <= 1'b0;
            slot_ok_reg <= 1'b0;
            found_reg   <= 1'b0;
            any_reg     <= 1'b0;
            lft_ok_reg  <= 1'b0;
            rgt_ok_reg  <= 1'b0;
            emp_ok_reg  <= 1'b0;
            for (int i = 0; i < HELD_SLOTS; i++)
            begin
                held_ok_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            hcnt_reg    <= hcnt_next;
            pick_ok_reg <= pick_ok_next;
            slot_ok_reg <= slot_ok_next;
            found_reg   <= found_next;
            any_reg     <= any_next;
            lft_ok_reg  <= lft_ok_next;
            rgt_ok_reg  <= rgt_ok_next;
            emp_ok_reg  <= emp_ok_next;
            if (held_clr)
            begin
                for (int i = 0; i < HELD_SLOTS; i++)
                begin
                    held_ok_reg[i] <= 1'b0;
                end
            end
            else if (held_set)
            begin
                held_ok_reg[slot_reg] <= 1'b1;
            end
            else if (held_free)
            begin
                held_ok_reg[slot_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            req_reg  <= request_size;
            own_reg  <= owner_id[OWNER_BITS-1:0];
        end
        pick_reg   <= pick_next;
        pick_s_reg <= pick_s_next;
        pick_l_reg <= pick_l_next;
        lft_reg    <= lft_next;
        rgt_reg    <= rgt_next;
        emp_reg    <= emp_next;
        rgt_l_reg  <= rgt_l_next;
        slot_reg   <= slot_next;
        low_reg    <= low_next;
        tot_reg    <= tot_next;
        st_reg     <= st_next;
        gb_reg     <= gb_next;
        gl_reg     <= gl_next;
        if (held_set)
        begin
            held_owner_reg[slot_reg] <= own_reg;
            held_start_reg[slot_reg] <= pick_s_reg;
            held_len_reg[slot_reg]   <= (leftover <= {1'b0, thr_reg}) ? pick_l_reg : req_reg;
        end
    end

    assign in_stall     = (state_reg != S_IDLE) || merge_reg;
    assign out_valid    = (state_reg == S_DONE);
    assign status       = st_reg;
    assign grant_begin  = gb_reg;
    assign grant_length = gl_reg;

endmodule
